// ----- hdl/nearest_neighbour_tour_defines.svh -----
// assertion macros for the tour builder
`ifndef NEAREST_NEIGHBOUR_TOUR_DEFINES_SVH
`define NEAREST_NEIGHBOUR_TOUR_DEFINES_SVH

`ifndef SYNTHESIS
`define NNT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nnt assertion failed");
`define NNT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nnt assertion failed");
`else
`define NNT_ASSERT(lbl, clk, rstn, prop)
`define NNT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/nnt_pkg.sv -----
package nnt_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_FRAC_DEF = 10;
  localparam int COORD_W        = 31;
  localparam int IDX_OUT_W      = 6;
  localparam int DIST_W         = 33;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_OUT_W-1:0]      pidx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_CAP, ST_EMIT, ST_SCAN,
    ST_DIFF, ST_MUL, ST_ADD, ST_SQRT, ST_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd0;
    logic cap_cur;
    logic emit;
    logic finish;
    logic skip;
    logic diff;
    logic mul;
    logic add;
    logic sqrt_step;
    logic decide;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic cand_visited;
    logic last_step;
    logic sqrt_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/nnt_if.sv -----
interface nnt_in_if;
  logic              valid;
  logic              ready;
  nnt_pkg::coord_t   coord_x;
  nnt_pkg::coord_t   coord_y;
  logic              final_point;
  modport source (output valid, coord_x, coord_y, final_point, input ready);
  modport sink   (input valid, coord_x, coord_y, final_point, output ready);
endinterface

interface nnt_out_if;
  logic              valid;
  logic              ready;
  nnt_pkg::pidx_t    point_index;
  logic              tour_end;
  modport source (output valid, point_index, tour_end, input ready);
  modport sink   (input valid, point_index, tour_end, output ready);
endinterface

// ----- hdl/nnt_datapath.sv -----
`include "nearest_neighbour_tour_defines.svh"

module nnt_datapath #(
  parameter int MAX_POINTS      = nnt_pkg::MAX_POINTS_DEF,
  parameter int COORD_FRAC_BITS = nnt_pkg::COORD_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nnt_pkg::cmd_t       cmd,
  output nnt_pkg::stat_t      stat,
  input  nnt_pkg::coord_t     in_x,
  input  nnt_pkg::coord_t     in_y,
  input  logic                in_final,
  output logic                out_valid,
  input  logic                out_ready,
  output nnt_pkg::pidx_t      out_index,
  output logic                out_end
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = nnt_pkg::DIST_W;
  localparam logic [DW-1:0] HALF =
    (COORD_FRAC_BITS > 0) ? DW'(1) << (COORD_FRAC_BITS - 1) : '0;

  nnt_pkg::coord_t mem_x [MAX_POINTS];
  nnt_pkg::coord_t mem_y [MAX_POINTS];
  nnt_pkg::coord_t rd_x_r, rd_y_r;
  nnt_pkg::coord_t cur_x_r, cur_y_r, cand_x_r, cand_y_r, best_x_r, best_y_r;

  logic [CNT_W-1:0]      cnt_r, n_r, k_r, i_r;
  logic [IDX_W-1:0]      cur_r, best_r, rd_addr;
  logic [MAX_POINTS-1:0] visited_r;
  logic                  found_r;
  logic [DW-1:0]         best_d_r, d_rnd;
  logic [31:0]           dx_r, dy_r;
  logic [63:0]           sqx_r, sqy_r, s_r;
  logic [33:0]           rem_r;
  logic [31:0]           root_r;
  logic [4:0]            it_r;
  logic [35:0]           rem_sh, trial;
  logic                  ge;
  logic signed [31:0]    dxs, dys;
  logic                  out_valid_r, out_end_r;
  nnt_pkg::pidx_t        out_index_r;

  // memory: one write port, one registered read port
  assign rd_addr = cmd.rd0 ? '0 : i_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r < CNT_W'(MAX_POINTS)) begin
      mem_x[cnt_r[IDX_W-1:0]] <= in_x;
      mem_y[cnt_r[IDX_W-1:0]] <= in_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign dxs = 32'(signed'(rd_x_r)) - 32'(signed'(cur_x_r));
  assign dys = 32'(signed'(rd_y_r)) - 32'(signed'(cur_y_r));

  // one root bit per cycle
  assign rem_sh = {rem_r, s_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    if (COORD_FRAC_BITS == 0) begin
      d_rnd = DW'(root_r) + DW'(rem_r > 34'(root_r));
    end else begin
      d_rnd = (DW'(root_r) + HALF) >> COORD_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      n_r         <= '0;
      k_r         <= '0;
      i_r         <= '0;
      cur_r       <= '0;
      visited_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
    end else begin
      if (out_valid_r && out_ready && !cmd.emit) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        if (cnt_r < CNT_W'(MAX_POINTS)) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (in_final) begin
          n_r   <= (cnt_r < CNT_W'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;
          k_r   <= '0;
          cur_r <= '0;
        end
      end
      if (cmd.cap_cur) begin
        cur_x_r <= rd_x_r;
        cur_y_r <= rd_y_r;
      end
      if (cmd.emit) begin
        out_valid_r          <= 1'b1;
        out_index_r          <= nnt_pkg::IDX_OUT_W'(cur_r);
        out_end_r            <= stat.last_step;
        if (!cmd.finish) begin
          visited_r[cur_r]   <= 1'b1;
        end
        i_r                  <= '0;
        found_r              <= 1'b0;
        best_r               <= cur_r;
      end
      if (cmd.finish) begin
        visited_r <= '0;
        cnt_r     <= '0;
      end
      if (cmd.skip) begin
        i_r <= i_r + 1'b1;
      end
      if (cmd.diff) begin
        dx_r     <= dxs[31] ? 32'(-dxs) : 32'(dxs);
        dy_r     <= dys[31] ? 32'(-dys) : 32'(dys);
        cand_x_r <= rd_x_r;
        cand_y_r <= rd_y_r;
      end
      if (cmd.mul) begin
        sqx_r <= 64'(dx_r) * 64'(dx_r);
        sqy_r <= 64'(dy_r) * 64'(dy_r);
      end
      if (cmd.add) begin
        s_r    <= sqx_r + sqy_r;
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
      end
      if (cmd.sqrt_step) begin
        rem_r  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
        root_r <= {root_r[30:0], ge};
        s_r    <= {s_r[61:0], 2'b00};
        it_r   <= it_r + 1'b1;
      end
      if (cmd.decide) begin
        if (!found_r || d_rnd < best_d_r) begin
          found_r  <= 1'b1;
          best_d_r <= d_rnd;
          best_r   <= i_r[IDX_W-1:0];
          best_x_r <= cand_x_r;
          best_y_r <= cand_y_r;
        end
        i_r <= i_r + 1'b1;
      end
      if (cmd.advance) begin
        cur_r   <= best_r;
        cur_x_r <= best_x_r;
        cur_y_r <= best_y_r;
        k_r     <= k_r + 1'b1;
      end
    end
  end

  assign stat.scan_done    = (i_r == n_r);
  assign stat.cand_visited = visited_r[i_r[IDX_W-1:0]];
  assign stat.last_step    = (k_r == n_r - 1'b1);
  assign stat.sqrt_last    = (it_r == '1);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_end   = out_end_r;

  `NNT_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> stat.out_free)
  `NNT_ASSERT(a_emit_unvisited, clk, rst_n, cmd.emit |-> !visited_r[cur_r])
  `NNT_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(MAX_POINTS))
  `NNT_ASSERT_NEXT(a_finish_clears, clk, rst_n, cmd.finish, cnt_r == '0 && visited_r == '0)

endmodule

// ----- hdl/nnt_ctrl.sv -----
module nnt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_final,
  output logic            in_ready,
  input  nnt_pkg::stat_t  stat,
  output nnt_pkg::cmd_t   cmd
);

  nnt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      nnt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final) begin
            state_nxt = nnt_pkg::ST_RD0;
          end
        end
      end
      nnt_pkg::ST_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = nnt_pkg::ST_CAP;
      end
      nnt_pkg::ST_CAP: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = nnt_pkg::ST_EMIT;
      end
      nnt_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_step) begin
            cmd.finish = 1'b1;
            state_nxt  = nnt_pkg::ST_IDLE;
          end else begin
            state_nxt = nnt_pkg::ST_SCAN;
          end
        end
      end
      nnt_pkg::ST_SCAN: begin
        priority if (stat.scan_done) begin
          cmd.advance = 1'b1;
          state_nxt   = nnt_pkg::ST_EMIT;
        end else if (stat.cand_visited) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = nnt_pkg::ST_DIFF;
        end
      end
      nnt_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = nnt_pkg::ST_MUL;
      end
      nnt_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = nnt_pkg::ST_ADD;
      end
      nnt_pkg::ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = nnt_pkg::ST_SQRT;
      end
      nnt_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_nxt = nnt_pkg::ST_DECIDE;
        end
      end
      nnt_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = nnt_pkg::ST_SCAN;
      end
      default: begin
        state_nxt = nnt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/nearest_neighbour_tour.sv -----
// channel   dir  word                                   handshake
// in_if     in   coord_x, coord_y, final_point          valid/ready
// out_if    out  point_index, tour_end                  valid/ready
//
// a point word without final_point is stored and gives nothing
// on final_point the tour is built: each unvisited candidate passes through
// read, difference, square, sum, the one-bit-a-cycle square root and the compare
// all candidates of a tour take turns on the shared root unit
// reset is synchronous, active low; the stores need no clearing pass
// a stalled result word holds the next emission; loading resumes once the tour ends

module nearest_neighbour_tour #(
  parameter int MAX_POINTS      = nnt_pkg::MAX_POINTS_DEF,
  parameter int COORD_FRAC_BITS = nnt_pkg::COORD_FRAC_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nnt_in_if.sink    in_if,
  nnt_out_if.source out_if
);

  // command and status between controller and datapath
  nnt_pkg::cmd_t  cmd;
  nnt_pkg::stat_t stat;

  // controller: walks load, emit, scan and the per-candidate distance steps
  nnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_final (in_if.final_point),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: point memory, visited marks, distance unit, result register
  nnt_datapath #(
    .MAX_POINTS      (MAX_POINTS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_x      (in_if.coord_x),
    .in_y      (in_if.coord_y),
    .in_final  (in_if.final_point),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_index (out_if.point_index),
    .out_end   (out_if.tour_end)
  );

endmodule

// ----- sim/nearest_neighbour_tour_test.sv -----
module nearest_neighbour_tour_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS    = nnt_pkg::MAX_POINTS_DEF;
  localparam int FRAC       = nnt_pkg::COORD_FRAC_DEF;
  // the limit covers the slowest tour, padded for stalls and gaps
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct {
    nnt_pkg::pidx_t point_index;
    logic           tour_end;
  } tour_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nnt_in_if  in_if ();
  nnt_out_if out_if ();

  nearest_neighbour_tour dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #2 clk = ~clk;

  // predictor state: a copy of the point stores and the fill level
  longint     px [MAX_PTS];
  longint     py [MAX_PTS];
  int         fill_level;

  tour_step_t tour_queue[$];
  int         errors;
  int         points_sent;
  int         tours_built;
  int         steps_checked;
  int         cycle_count;
  bit         quiet;        // no idling on either side once set
  int         sink_stall;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // exact floor square root, one result bit per pass
  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // euclidean distance in whole units, halves away from zero
  function automatic longint unsigned whole_distance(input int a, input int b);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned r;
    dx = px[a] - px[b];
    dy = py[a] - py[b];
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
    r = root_floor(sq);
    if (FRAC == 0) return r + ((sq - r * r > r) ? 1 : 0);
    return (r + (64'd1 << (FRAC - 1))) >> FRAC;
  endfunction

  // greedy tour over the loaded points, expected steps queued in order
  task automatic build_expected_tour();
    bit              seen [MAX_PTS];
    int              cur;
    int              best_idx;
    bit              found;
    longint unsigned best;
    longint unsigned d;
    tour_step_t      step;
    foreach (seen[i]) seen[i] = 1'b0;
    cur = 0;
    for (int k = 0; k < fill_level; k++) begin
      seen[cur] = 1'b1;
      step.point_index = nnt_pkg::pidx_t'(cur);
      step.tour_end = (k + 1 == fill_level);
      tour_queue = {tour_queue, step};
      found = 1'b0;
      best = 0;
      best_idx = cur;
      for (int i = 0; i < fill_level; i++) begin
        if (!seen[i]) begin
          d = whole_distance(cur, i);
          if (!found || d < best) begin
            found = 1'b1;
            best = d;
            best_idx = i;
          end
        end
      end
      cur = best_idx;
    end
    fill_level = 0;
    tours_built++;
  endtask

  // sends one point word and updates the predictor once it is taken
  task automatic send_point(input nnt_pkg::coord_t x, input nnt_pkg::coord_t y,
                            input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.coord_x     <= x;
    in_if.coord_y     <= y;
    in_if.final_point <= last;
    do @(posedge clk); while (!in_if.ready);
    points_sent++;
    if (fill_level < MAX_PTS) begin
      px[fill_level] = longint'(x);
      py[fill_level] = longint'(y);
      fill_level++;
    end
    if (last) build_expected_tour();
  endtask

  task automatic send_set(input nnt_pkg::coord_t xs[$], input nnt_pkg::coord_t ys[$]);
    foreach (xs[i]) send_point(xs[i], ys[i], i == xs.size() - 1);
  endtask

  // one point alone still gives a one-step tour
  task automatic test_single_point();
    send_point(31'sd12345, -31'sd999, 1'b1);
  endtask

  // coordinates at both ends of the range, largest possible distances
  task automatic test_coordinate_extremes();
    nnt_pkg::coord_t xs[$];
    nnt_pkg::coord_t ys[$];
    xs = {31'h3fffffff, 31'h40000000, 31'h40000000, 31'h3fffffff, 31'h00000000};
    ys = {31'h3fffffff, 31'h40000000, 31'h3fffffff, 31'h40000000, 31'h7fffffff};
    send_set(xs, ys);
  endtask

  // equal whole distances go to the lower index
  task automatic test_tie_break();
    nnt_pkg::coord_t xs[$];
    nnt_pkg::coord_t ys[$];
    xs = {31'sd0, 31'sd1024, -31'sd1024, 31'sd0, 31'sd0};
    ys = {31'sd0, 31'sd0, 31'sd0, 31'sd1024, -31'sd1024};
    send_set(xs, ys);
  endtask

  // half a unit rounds up, just under half rounds down
  task automatic test_half_rounding();
    nnt_pkg::coord_t xs[$];
    nnt_pkg::coord_t ys[$];
    xs = {31'sd0, 31'sd512, -31'sd511, 31'sd1536, -31'sd1535};
    ys = {31'sd0, 31'sd0, 31'sd0, 31'sd0, 31'sd0};
    send_set(xs, ys);
  endtask

  // a full set: loads past the limit are dropped, the last one still starts the tour
  task automatic test_full_set_overflow();
    for (int i = 0; i < MAX_PTS + 2; i++)
      send_point(nnt_pkg::coord_t'($urandom_range(0, 32767)) - 31'sd16384,
                 nnt_pkg::coord_t'($urandom_range(0, 32767)) - 31'sd16384,
                 i == MAX_PTS + 1);
  endtask

  // mostly small sets; a narrow grid keeps ties frequent, the wide range hits every bit
  task automatic test_random_sets(input int budget);
    int              sent;
    int              n;
    int              mode;
    nnt_pkg::coord_t x;
    nnt_pkg::coord_t y;
    sent = 0;
    while (sent < budget) begin
      if (sent > budget * 4 / 5) quiet = 1'b1;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        case (mode)
          0: begin
            x = nnt_pkg::coord_t'($urandom);
            y = nnt_pkg::coord_t'($urandom);
          end
          1: begin
            x = nnt_pkg::coord_t'($urandom_range(0, 8) * 512) - 31'sd2048;
            y = nnt_pkg::coord_t'($urandom_range(0, 8) * 512) - 31'sd2048;
          end
          default: begin
            x = nnt_pkg::coord_t'($urandom_range(0, 2000000)) - 31'sd1000000;
            y = nnt_pkg::coord_t'($urandom_range(0, 2000000)) - 31'sd1000000;
          end
        endcase
        send_point(x, y, i == n - 1);
      end
      sent += n;
    end
  endtask

  // result side: random stall bursts on ready
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      if (sink_stall == 0) out_if.ready <= 1'b1;
    end else if (rst_n && !quiet && $urandom_range(0, 6) == 0) begin
      sink_stall = $urandom_range(1, 9);
      out_if.ready <= 1'b0;
    end
  end

  // compare every taken result word against the oldest expected step
  always @(posedge clk) begin
    tour_step_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tour_queue.size() == 0) begin
        report_mismatch("unexpected word, point_index", out_if.point_index, -1);
      end else begin
        want = tour_queue.pop_front();
        steps_checked++;
        if (out_if.point_index !== want.point_index)
          report_mismatch("point_index", out_if.point_index, want.point_index);
        if (out_if.tour_end !== want.tour_end)
          report_mismatch("tour_end", out_if.tour_end, want.tour_end);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("nearest_neighbour_tour_test: FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.coord_x     = '0;
    in_if.coord_y     = '0;
    in_if.final_point = 1'b0;
    out_if.ready      = 1'b1;
    errors = 0;
    points_sent = 0;
    tours_built = 0;
    steps_checked = 0;
    cycle_count = 0;
    sink_stall = 0;
    fill_level = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_point();
    test_coordinate_extremes();
    test_tie_break();
    test_half_rounding();
    test_full_set_overflow();
    test_random_sets(220);

    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (tour_queue.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d point words, built %0d tours, checked %0d tour steps",
             points_sent, tours_built, steps_checked);
    $display("covered extremes, ties, half rounding, a full set with dropped loads");
    if (errors == 0) begin
      $display("nearest_neighbour_tour_test: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("nearest_neighbour_tour_test: FAIL");
    end
    $finish;
  end

endmodule
